// ===== rtl/core/skrt_pkg.sv =====
// ----------------------------------------------------------------------------
// skrt_pkg
// shared types and codes of the sorted keyed record table
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_LIST   = 3'd4;
  localparam logic [2:0] OP_PREFIX = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [15:0] key;
    logic [63:0] name;
    logic [63:0] country;
    logic [7:0]  age;
  } rec_t;

endpackage

// ===== rtl/core/skrt_match.sv =====
// ----------------------------------------------------------------------------
// skrt_match
// shared compare unit: key equality, key order and name prefix match
// ----------------------------------------------------------------------------
module skrt_match #(
  parameter int NAME_BYTES = 8
) (
  input  logic [15:0] slot_key,
  input  logic [15:0] req_key,
  input  logic [63:0] slot_name,
  input  logic [63:0] req_name,
  input  logic [3:0]  prefix_length,
  output logic        key_eq,
  output logic        key_gt,
  output logic        name_hit
);
  always_comb begin
    logic done;
    key_eq   = (slot_key == req_key);
    key_gt   = (slot_key > req_key);
    name_hit = 1'b1;
    done     = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (!done && (4'(i) < prefix_length)) begin
        if (slot_name[8*i +: 8] != req_name[8*i +: 8]) begin
          name_hit = 1'b0;
          done     = 1'b1;
        end else if (slot_name[8*i +: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/sorted_keyed_record_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_keyed_record_table_unit
// sorted record table with insert, delete, lookup, clear, list and prefix list requests
// ----------------------------------------------------------------------------
// one request enters on in_valid/in_stall; its results leave on out_valid/out_stall.
// records sit in a memory with one read and one write port; a small sequencer
// walks it slot by slot (read, then compare or move) through a shared
// compare unit. in_stall is high from acceptance until the walk ends, so the
// next request can enter while the final result still waits to be taken.
// insert searches up to the insert point, then moves records up from the end;
// delete searches up to the key, then moves the rest down; lookup and lists
// scan the held records; clear and unused codes go straight to the result.
// in_stall drops at the same edge that loads the final result.
// a list holds each match back one step so that last lands on the final one.
// reset empties the table and drops any pending result; no clearing pass.
// a stalled result holds its fields and the walk waits before emitting more.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table_unit #(
  parameter int ENTRIES    = 32,
  parameter int NAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_key,
  input  logic [63:0] in_name_text,
  input  logic [63:0] in_country_text,
  input  logic [7:0]  in_age,
  input  logic [3:0]  in_prefix_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_valid_res,
  output logic [15:0] out_key,
  output logic [63:0] out_name,
  output logic [63:0] out_country,
  output logic [7:0]  out_age,
  output logic [5:0]  out_entry_count,
  output logic        out_last
);
  import skrt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [63:0] NAME_MASK = (NAME_BYTES >= 8) ? {64{1'b1}} :
    ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1; // issue read of idx
  localparam logic [3:0] S_CHK  = 4'd2; // data of idx available
  localparam logic [3:0] S_IPOS = 4'd3; // insert point known, full check
  localparam logic [3:0] S_IRD  = 4'd4; // insert: read idx-1 or place record
  localparam logic [3:0] S_IWR  = 4'd5; // insert: move idx-1 up to idx
  localparam logic [3:0] S_DRD  = 4'd6; // delete: read idx+1 or finish
  localparam logic [3:0] S_DWR  = 4'd7; // delete: move idx+1 down to idx
  localparam logic [3:0] S_OUT  = 4'd8; // load final result

  logic [3:0]    state_r;
  logic [2:0]    op_r;
  rec_t          req_r;
  logic [3:0]    plen_r;
  logic [CW-1:0] occ_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;   // insert: where the new record lands
  logic [1:0]    res_st_r;
  rec_t          held_r;  // lookup hit or list match not yet emitted
  logic          hold_v_r;

  rec_t mem [ENTRIES];
  rec_t rd_r;
  logic          we;
  logic [AW-1:0] wa;
  rec_t          wd;
  logic [AW-1:0] ra;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  logic key_eq, key_gt, name_hit;
  skrt_match #(.NAME_BYTES(NAME_BYTES)) u_match (
    .slot_key(rd_r.key), .req_key(req_r.key), .slot_name(rd_r.name),
    .req_name(req_r.name), .prefix_length(plen_r),
    .key_eq(key_eq), .key_gt(key_gt), .name_hit(name_hit)
  );

  logic        ov_r;
  logic [1:0]  o_st_r;
  logic        o_vr_r, o_last_r;
  rec_t        o_rec_r;
  logic [5:0]  o_cnt_r;

  assign in_stall        = (state_r != S_IDLE);
  assign out_status      = o_st_r;
  assign out_valid_res   = o_vr_r;
  assign out_key         = o_rec_r.key;
  assign out_name        = o_rec_r.name;
  assign out_country     = o_rec_r.country;
  assign out_age         = o_rec_r.age;
  assign out_entry_count = o_cnt_r;
  assign out_last        = o_last_r;
  assign out_valid       = ov_r;

  logic out_free, is_list, is_scan, list_match, emit_mid, emit_end;
  assign out_free   = !ov_r || !out_stall;
  assign is_list    = (op_r == OP_LIST) || (op_r == OP_PREFIX);
  assign is_scan    = is_list || (op_r == OP_INSERT) || (op_r == OP_DELETE) ||
                      (op_r == OP_LOOKUP);
  assign list_match = (op_r == OP_LIST) || name_hit;
  // a new match pushes the held one out with last low
  assign emit_mid   = (state_r == S_CHK) && is_list && list_match && hold_v_r && out_free;
  assign emit_end   = (state_r == S_OUT) && out_free;

  // read address: insert shift reads below idx, delete shift above
  always_comb begin
    ra = idx_r[AW-1:0];
    if (state_r == S_IRD) ra = AW'(idx_r - CW'(1));
    else if (state_r == S_DRD) ra = AW'(idx_r + CW'(1));
  end

  always_comb begin
    we = 1'b0;
    wa = idx_r[AW-1:0];
    wd = rd_r;
    if (state_r == S_IWR || state_r == S_DWR) begin
      we = 1'b1;
    end else if (state_r == S_IRD && idx_r == pos_r) begin
      we = 1'b1;
      wd = req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_operation;
            req_r    <= '{in_key, in_name_text & NAME_MASK, in_country_text, in_age};
            plen_r   <= in_prefix_length;
            idx_r    <= '0;
            hold_v_r <= 1'b0;
            res_st_r <= ST_OK;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          if (op_r == OP_CLEAR) begin
            occ_r   <= '0;
            state_r <= S_OUT;
          end else if (!is_scan) begin
            state_r <= S_OUT;
          end else if (idx_r >= occ_r) begin
            // scan ran off the end
            if (op_r == OP_INSERT) begin
              pos_r   <= idx_r;
              state_r <= S_IPOS;
            end else begin
              if (op_r == OP_DELETE || op_r == OP_LOOKUP) res_st_r <= ST_NOTFOUND;
              state_r <= S_OUT;
            end
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (op_r == OP_INSERT) begin
            if (key_eq) begin
              res_st_r <= ST_DUP; state_r <= S_OUT;
            end else if (key_gt) begin
              pos_r <= idx_r; state_r <= S_IPOS;
            end else begin
              idx_r <= idx_r + CW'(1); state_r <= S_RD;
            end
          end else if (op_r == OP_DELETE) begin
            if (key_eq) begin
              state_r <= S_DRD;
            end else begin
              idx_r <= idx_r + CW'(1); state_r <= S_RD;
            end
          end else if (op_r == OP_LOOKUP) begin
            if (key_eq) begin
              held_r <= rd_r; hold_v_r <= 1'b1; state_r <= S_OUT;
            end else begin
              idx_r <= idx_r + CW'(1); state_r <= S_RD;
            end
          end else begin
            if (list_match) begin
              if (!hold_v_r || out_free) begin
                held_r <= rd_r; hold_v_r <= 1'b1;
                idx_r <= idx_r + CW'(1); state_r <= S_RD;
              end
            end else begin
              idx_r <= idx_r + CW'(1); state_r <= S_RD;
            end
          end
        end
        S_IPOS: begin
          if (occ_r >= CW'(ENTRIES)) begin
            res_st_r <= ST_FULL; state_r <= S_OUT;
          end else begin
            idx_r <= occ_r; state_r <= S_IRD;
          end
        end
        S_IRD: begin
          if (idx_r == pos_r) begin
            occ_r <= occ_r + CW'(1); state_r <= S_OUT;
          end else state_r <= S_IWR;
        end
        S_IWR: begin
          idx_r <= idx_r - CW'(1); state_r <= S_IRD;
        end
        S_DRD: begin
          if (idx_r + CW'(1) >= occ_r) begin
            occ_r <= occ_r - CW'(1); state_r <= S_OUT;
          end else state_r <= S_DWR;
        end
        S_DWR: begin
          idx_r <= idx_r + CW'(1); state_r <= S_DRD;
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_mid) begin
      ov_r <= 1'b1; o_st_r <= ST_OK; o_vr_r <= 1'b1; o_rec_r <= held_r;
      o_cnt_r <= 6'(occ_r); o_last_r <= 1'b0;
    end else if (emit_end) begin
      ov_r <= 1'b1; o_st_r <= res_st_r; o_vr_r <= hold_v_r;
      o_rec_r <= hold_v_r ? held_r : '0;
      o_cnt_r <= 6'(occ_r); o_last_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  property p_busy_no_accept;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> in_stall;
  endproperty
  a_busy: assert property (p_busy_no_accept) else $error("accept while busy");

  property p_occ_bound;
    @(posedge clk) disable iff (!rst_n) occ_r <= CW'(ENTRIES);
  endproperty
  a_occ: assert property (p_occ_bound) else $error("occupancy overflow");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (ov_r && out_stall) |=> (ov_r && $stable(o_rec_r) && $stable(o_last_r) &&
                               $stable(o_st_r) && $stable(o_vr_r) && $stable(o_cnt_r));
  endproperty
  a_hold: assert property (p_out_hold) else $error("result changed under stall");

endmodule

// ===== tb/sv/sorted_keyed_record_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// sorted_keyed_record_table_unit_test
// self-checking bench: predicts every result of the record table and compares
// ----------------------------------------------------------------------------
module sorted_keyed_record_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skrt_pkg::*;

  localparam int ENTRIES    = 32;
  localparam int NAME_BYTES = 8;
  localparam int WATCHDOG   = 20000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] key;
    logic [63:0] name_text;
    logic [63:0] country_text;
    logic [7:0]  age;
    logic [3:0]  prefix_length;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid_res;
    logic [15:0] key;
    logic [63:0] name;
    logic [63:0] country;
    logic [7:0]  age;
    logic [5:0]  entry_count;
    logic        last;
  } result_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_operation;
  logic [15:0] in_key;
  logic [63:0] in_name_text, in_country_text;
  logic [7:0] in_age;
  logic [3:0] in_prefix_length;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic out_valid_res;
  logic [15:0] out_key;
  logic [63:0] out_name, out_country;
  logic [7:0] out_age;
  logic [5:0] out_entry_count;
  logic out_last;

  sorted_keyed_record_table_unit #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES)) u_dut (.*);

  request_t pending_q[$];
  result_t  expected_q[$];
  rec_t     table_recs[ENTRIES];
  int       held;
  int       errors;
  int       idle_pct_in, idle_pct_out;
  int       quiet_cycles;
  logic     timed_out;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic result_t make_result(logic [1:0] st, int slot, logic lst);
    result_t r;
    r = '0;
    r.status = st;
    if (slot >= 0) begin
      r.valid_res = 1'b1;
      r.key = table_recs[slot].key;
      r.name = table_recs[slot].name;
      r.country = table_recs[slot].country;
      r.age = table_recs[slot].age;
    end
    r.entry_count = held[5:0];
    r.last = lst;
    return r;
  endfunction

  function automatic int find_slot(logic [15:0] k);
    for (int i = 0; i < held; i++) if (table_recs[i].key == k) return i;
    return -1;
  endfunction

  function automatic bit name_has_prefix(logic [63:0] nm, logic [63:0] pre, int len);
    if (len > NAME_BYTES) len = NAME_BYTES;
    for (int i = 0; i < len; i++) begin
      if (nm[8*i +: 8] != pre[8*i +: 8]) return 0;
      if (nm[8*i +: 8] == 8'h00) return 1;
    end
    return 1;
  endfunction

  // apply one request to the shadow table and queue its results
  task automatic predict_table(input request_t rq);
    int slot, n;
    case (rq.operation)
      OP_INSERT: begin
        if (find_slot(rq.key) >= 0) expected_q.push_back(make_result(ST_DUP, -1, 1'b1));
        else if (held >= ENTRIES) expected_q.push_back(make_result(ST_FULL, -1, 1'b1));
        else begin
          slot = held;
          while (slot > 0 && table_recs[slot-1].key > rq.key) begin
            table_recs[slot] = table_recs[slot-1];
            slot--;
          end
          table_recs[slot] = '{rq.key, rq.name_text, rq.country_text, rq.age};
          held++;
          expected_q.push_back(make_result(ST_OK, -1, 1'b1));
        end
      end
      OP_DELETE: begin
        slot = find_slot(rq.key);
        if (slot < 0) expected_q.push_back(make_result(ST_NOTFOUND, -1, 1'b1));
        else begin
          for (int i = slot; i + 1 < held; i++) table_recs[i] = table_recs[i+1];
          held--;
          expected_q.push_back(make_result(ST_OK, -1, 1'b1));
        end
      end
      OP_LOOKUP: begin
        slot = find_slot(rq.key);
        expected_q.push_back(make_result(slot < 0 ? ST_NOTFOUND : ST_OK, slot, 1'b1));
      end
      OP_CLEAR: begin
        held = 0;
        expected_q.push_back(make_result(ST_OK, -1, 1'b1));
      end
      OP_LIST, OP_PREFIX: begin
        n = 0;
        for (int i = 0; i < held; i++) begin
          if (rq.operation == OP_PREFIX &&
              !name_has_prefix(table_recs[i].name, rq.name_text, rq.prefix_length))
            continue;
          expected_q.push_back(make_result(ST_OK, i, 1'b0));
          n++;
        end
        if (n == 0) expected_q.push_back(make_result(ST_OK, -1, 1'b1));
        else expected_q[$].last = 1'b1;
      end
      default: expected_q.push_back(make_result(ST_OK, -1, 1'b1));
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_table(pending_q.pop_front());
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct_in) begin
        in_valid <= 1'b1;
        in_operation <= pending_q[0].operation;
        in_key <= pending_q[0].key;
        in_name_text <= pending_q[0].name_text;
        in_country_text <= pending_q[0].country_text;
        in_age <= pending_q[0].age;
        in_prefix_length <= pending_q[0].prefix_length;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'(out_key), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_status != want.status)
            report("status", 64'(out_status), 64'(want.status));
          if (out_valid_res != want.valid_res)
            report("valid_res", 64'(out_valid_res), 64'(want.valid_res));
          if (out_key != want.key) report("key", 64'(out_key), 64'(want.key));
          if (out_name != want.name) report("name", out_name, want.name);
          if (out_country != want.country) report("country", out_country, want.country);
          if (out_age != want.age) report("age", 64'(out_age), 64'(want.age));
          if (out_entry_count != want.entry_count)
            report("entry_count", 64'(out_entry_count), 64'(want.entry_count));
          if (out_last != want.last) report("last", 64'(out_last), 64'(want.last));
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct_out);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG && !timed_out) begin
      timed_out <= 1'b1;
      $display("sorted_keyed_record_table_unit_test failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic request_t build(logic [2:0] op, logic [15:0] k, logic [63:0] nm,
                                     logic [3:0] plen);
    request_t rq;
    rq.operation = op;
    rq.key = k;
    rq.name_text = nm;
    rq.country_text = rand64();
    rq.age = 8'($urandom());
    rq.prefix_length = plen;
    return rq;
  endfunction

  // names drawn from a small alphabet so prefixes actually hit
  function automatic logic [63:0] short_name();
    logic [63:0] nm;
    int len;
    nm = '0;
    len = int'($urandom_range(8));
    for (int i = 0; i < len; i++) nm[8*i +: 8] = 8'h41 + 8'($urandom_range(2));
    return nm;
  endfunction

  function automatic logic [15:0] pick_key();
    return ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
  endfunction

  task automatic fill_random(int count);
    int r;
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) op = OP_INSERT;
      else if (r < 55) op = OP_DELETE;
      else if (r < 70) op = OP_LOOKUP;
      else if (r < 73) op = OP_CLEAR;
      else if (r < 82) op = OP_LIST;
      else if (r < 97) op = OP_PREFIX;
      else op = 3'($urandom_range(6, 7));
      pending_q.push_back(build(op, pick_key(),
        ($urandom_range(4) == 0) ? rand64() : short_name(), 4'($urandom_range(15))));
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int pct_in[4];
    int pct_out[4];
    pct_in = '{0, 83, 0, 10};
    pct_out = '{0, 0, 83, 10};
    errors = 0;
    held = 0;
    timed_out = 1'b0;
    quiet_cycles = 0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_operation = '0;
    in_key = '0;
    in_name_text = '0;
    in_country_text = '0;
    in_age = '0;
    in_prefix_length = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, misses, extremes, duplicates, prefixes, unused codes, full table, clear
    pending_q.push_back(build(OP_LIST, '0, '0, '0));
    pending_q.push_back(build(OP_LOOKUP, 16'hffff, '0, '0));
    pending_q.push_back(build(OP_DELETE, '0, '0, '0));
    pending_q.push_back('{OP_INSERT, 16'hffff, '1, '1, 8'hff, 4'hf});
    pending_q.push_back('{OP_INSERT, 16'h0000, '0, '0, 8'h00, 4'h0});
    pending_q.push_back(build(OP_INSERT, 16'h0000, 64'h4241, '0));
    pending_q.push_back(build(OP_INSERT, 16'h0100, 64'h00_4241, '0));
    pending_q.push_back(build(OP_INSERT, 16'h0050, 64'h43_4241, '0));
    pending_q.push_back(build(OP_PREFIX, '0, 64'h4241, 4'd2));
    pending_q.push_back(build(OP_PREFIX, '0, 64'h4241, 4'hf));
    pending_q.push_back(build(OP_PREFIX, '0, '1, '0));
    pending_q.push_back(build(OP_PREFIX, '0, 64'h5a, 4'd1));
    pending_q.push_back(build(OP_LOOKUP, 16'h0050, '0, '0));
    pending_q.push_back(build(3'd6, '0, '0, '0));
    pending_q.push_back(build(3'd7, 16'hffff, '1, 4'hf));
    pending_q.push_back(build(OP_DELETE, 16'h0050, '0, '0));
    pending_q.push_back(build(OP_LIST, '0, '0, '0));
    for (int k = 0; k < ENTRIES + 1; k++)
      pending_q.push_back(build(OP_INSERT, 16'(1000 + k * 7), short_name(), '0));
    pending_q.push_back(build(OP_LIST, '0, '0, '0));
    pending_q.push_back(build(OP_CLEAR, '0, '0, '0));
    pending_q.push_back(build(OP_LIST, '0, '0, '0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct_in = pct_in[ph];
      idle_pct_out = pct_out[ph];
      fill_random(90);
      wait_drained();
    end
    idle_pct_in = 0;
    idle_pct_out = 0;
    repeat (50) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("sorted_keyed_record_table_unit_test passed");
    end else begin
      $display("sorted_keyed_record_table_unit_test failed");
    end
    $finish;
  end

endmodule
